/* hw/rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// Jacobi symbol unit package
// Shared constants, result codes and the result record that passes from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Default operand width of the arithmetic.
   localparam int WORD_BITS_DEFAULT = 32;

   // Widths of the stream fields.
   localparam int FIELD_BITS    = 32;
   localparam int SYMBOL_BITS   = 2;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 8;

   // Two's complement codes of the symbol value.
   localparam logic [SYMBOL_BITS-1:0] SYM_ZERO  = 2'b00;
   localparam logic [SYMBOL_BITS-1:0] SYM_PLUS  = 2'b01;
   localparam logic [SYMBOL_BITS-1:0] SYM_MINUS = 2'b11;

   // Residues of the modulus that matter for the sign rules.
   localparam logic [2:0] MOD8_ONE   = 3'd1;
   localparam logic [2:0] MOD8_SEVEN = 3'd7;
   localparam logic [1:0] MOD4_ONE   = 2'd1;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   bad_modulus;
   } jsu_result_type;

endpackage

/* hw/rtl/jsu_mod_unit.sv */
// ----------------------------------------------------------------------------
// Jacobi symbol unit remainder engine
// Restoring shift-subtract remainder, one dividend bit per cycle. The divisor
// must be non-zero. done is a single-cycle pulse with the remainder valid.
// ----------------------------------------------------------------------------
module jsu_mod_unit
   import jsu_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] shift_ff, shift_in;
   logic [WORD_BITS-1:0] divisor_ff, divisor_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS:0]   diff;

   // The running remainder stays below the divisor, so one bit of headroom
   // covers the shifted trial value.
   assign trial = {rem_ff, shift_ff[WORD_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_BITS'(WORD_BITS - 1);
         rem_in     = '0;
         shift_in   = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[WORD_BITS-2:0], 1'b0};
         if (!diff[WORD_BITS]) begin
            rem_in = diff[WORD_BITS-1:0];
         end else begin
            rem_in = trial[WORD_BITS-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* hw/rtl/jsu_ctrl.sv */
// ----------------------------------------------------------------------------
// Jacobi symbol unit sequencer
// Runs the rounds of the symbol: reduce through the shared remainder engine,
// strip factors of two one per cycle, apply the sign rules and swap.
// ----------------------------------------------------------------------------
module jsu_ctrl
   import jsu_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] value_a,
   input  logic [WORD_BITS-1:0] modulus_n,
   output logic                 idle,
   output logic                 res_valid,
   input  logic                 res_take,
   output jsu_result_type       result
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_REDUCE,
      ST_STRIP,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [WORD_BITS-1:0] top_ff, top_in;
   logic [WORD_BITS-1:0] bot_ff, bot_in;
   logic [WORD_BITS-1:0] odd_ff, odd_in;
   logic                 twos_ff, twos_in;
   logic                 neg_ff, neg_in;
   jsu_result_type       result_ff, result_in;

   logic                 mod_start;
   logic                 mod_done;
   logic [WORD_BITS-1:0] mod_rem;
   logic                 flip_twos;
   logic                 flip_recip;

   jsu_mod_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (top_ff),
      .divisor   (bot_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign mod_start = (state_ff == ST_LOAD);

   // An odd count of twos flips the sign unless the modulus is 1 or 7 mod 8, so
   // an even modulus in the first round flips it as well; reciprocity flips it
   // when neither value is 1 mod 4.
   assign flip_twos  = twos_ff && (bot_ff[2:0] != MOD8_ONE) && (bot_ff[2:0] != MOD8_SEVEN);
   assign flip_recip = (odd_ff[1:0] != MOD4_ONE) && (bot_ff[1:0] != MOD4_ONE);

   always_comb begin
      state_in  = state_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      odd_in    = odd_ff;
      twos_in   = twos_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               top_in = value_a;
               bot_in = modulus_n;
               neg_in = 1'b0;
               if (modulus_n == '0) begin
                  result_in.symbol      = SYM_ZERO;
                  result_in.bad_modulus = 1'b1;
                  state_in              = ST_DONE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mod_done) begin
               if (mod_rem == '0) begin
                  result_in.bad_modulus = 1'b0;
                  if (bot_ff == WORD_BITS'(1)) begin
                     result_in.symbol = neg_ff ? SYM_MINUS : SYM_PLUS;
                  end else begin
                     result_in.symbol = SYM_ZERO;
                  end
                  state_in = ST_DONE;
               end else begin
                  odd_in   = mod_rem;
                  twos_in  = 1'b0;
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (!odd_ff[0]) begin
               odd_in  = {1'b0, odd_ff[WORD_BITS-1:1]};
               twos_in = !twos_ff;
            end else begin
               neg_in   = neg_ff ^ flip_twos ^ flip_recip;
               top_in   = bot_ff;
               bot_in   = odd_ff;
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      odd_ff    <= odd_in;
      twos_ff   <= twos_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign result    = result_ff;

endmodule

/* hw/rtl/jacobi_symbol_unit.sv */
// ----------------------------------------------------------------------------
// Jacobi symbol unit
// Computes the Jacobi symbol (a|n) of two unsigned operands by the binary
// reciprocity rounds, sharing one bit-serial remainder engine.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction carries
//   -------   ---------  -----------------------------------------------------
//   req_      in         value_a [31:0], modulus_n [63:32]
//   rsp_      out        symbol [1:0] (two's complement), bad_modulus [2]
//
// Each round passes through a load state, the remainder engine, an inspection
// of the remainder, and a strip state that shifts out each factor of two and
// then swaps; the last round ends at the inspection. An item keeps req_tready
// low through all of its rounds, the result hand-over and the return to idle;
// a zero modulus needs no rounds and goes straight to the result hand-over.
// Reset clears the sequencer and the output register; no item is in flight.
// req_tready is high only while the sequencer is idle. A finished result sits
// in the output register while the next transaction is accepted; a result
// that finds that register still occupied holds the sequencer until it frees.
// ----------------------------------------------------------------------------
module jacobi_symbol_unit
   import jsu_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request stream. tdata: value_a [31:0], modulus_n [63:32].
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // Response stream. tdata: symbol [1:0], bad_modulus [2], zeros [7:3].
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [FIELD_BITS-1:0] req_value_a;
   logic [FIELD_BITS-1:0] req_modulus_n;
   logic [WORD_BITS-1:0]  word_a;
   logic [WORD_BITS-1:0]  word_n;
   logic                  req_accept;
   logic                  ctrl_idle;
   logic                  res_valid;
   logic                  res_take;
   jsu_result_type        result;

   logic                  rsp_valid_ff, rsp_valid_in;
   jsu_result_type        rsp_result_ff, rsp_result_in;

   assign req_value_a   = req_tdata[FIELD_BITS-1:0];
   assign req_modulus_n = req_tdata[2*FIELD_BITS-1:FIELD_BITS];

   // Only the low WORD_BITS of each operand take part; a wider word sees the
   // fields zero-extended.
   generate
      if (WORD_BITS <= FIELD_BITS) begin : g_narrow
         assign word_a = req_value_a[WORD_BITS-1:0];
         assign word_n = req_modulus_n[WORD_BITS-1:0];
      end else begin : g_wide
         assign word_a = {{(WORD_BITS-FIELD_BITS){1'b0}}, req_value_a};
         assign word_n = {{(WORD_BITS-FIELD_BITS){1'b0}}, req_modulus_n};
      end
   endgenerate

   assign req_tready = ctrl_idle;
   assign req_accept = req_tvalid && req_tready;

   jsu_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .value_a   (word_a),
      .modulus_n (word_n),
      .idle      (ctrl_idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .result    (result)
   );

   // The output register takes a new result whenever it is empty or its
   // current transaction completes in this cycle.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      if (res_take) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-SYMBOL_BITS-1){1'b0}},
                        rsp_result_ff.bad_modulus, rsp_result_ff.symbol};

   // A flagged modulus always comes with a zero symbol.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_result_ff.bad_modulus |-> rsp_result_ff.symbol == SYM_ZERO)
      else $error("bad modulus reported with a non-zero symbol");

   // The symbol is always one of its three legal codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result_ff.symbol == SYM_ZERO) ||
                     (rsp_result_ff.symbol == SYM_PLUS) ||
                     (rsp_result_ff.symbol == SYM_MINUS))
      else $error("illegal symbol code on the response");

   // Accepting a transaction makes the sequencer busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("request accepted while the previous one was still running");

   // A new response only appears when the sequencer handed over a result.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(res_take))
      else $error("response raised without a finished result");

endmodule

/* tb/tb_jacobi_symbol_unit.sv */
// ----------------------------------------------------------------------------
// Jacobi symbol unit testbench
// Streams operand pairs into the unit and predicts each symbol in the bench.
// Every response transaction is checked field by field against the oldest
// prediction. A short directed set covers the corner cases, then random pairs
// follow, weighted towards odd moduli, with some long reciprocity chains. Both sides
// of the streams stall at random, and the stall pattern changes by phase.
// ----------------------------------------------------------------------------
module tb_jacobi_symbol_unit;
   import jsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Sizes of the run. The cycle limit allows every item the cost of the slowest
   // one, plus long stalls on both sides, several times over.
   localparam int          RANDOM_ITEMS  = 400;
   localparam int          SETTLE_CYCLES = 3500;
   localparam int unsigned CYCLE_LIMIT   = 8_000_000;
   localparam int          REPORT_LIMIT  = 10;

   // One queued request. The hold flag makes the driver wait until every
   // outstanding response has come back before it offers this request.
   typedef struct {
      logic [FIELD_BITS-1:0] value_a;
      logic [FIELD_BITS-1:0] modulus_n;
      bit                    hold_for_idle;
   } jacobi_query_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // value_a [31:0], modulus_n [63:32]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;        // symbol [1:0], bad_modulus [2], zeros [7:3]

   jacobi_query_type query_queue[$];
   jsu_result_type   symbol_queue[$];
   int               item_total     = 0;
   int               accepted_items = 0;
   int               mismatches     = 0;
   int unsigned      cycle_count    = 0;

   jacobi_symbol_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // The binary reciprocity rounds. The sign is carried as a flag that records
   // an odd number of flips. A zero modulus is flagged and gives a zero symbol.
   function automatic jsu_result_type predict_jacobi(logic [FIELD_BITS-1:0] a_in,
                                                     logic [FIELD_BITS-1:0] n_in);
      jsu_result_type        res;
      logic [FIELD_BITS-1:0] top;
      logic [FIELD_BITS-1:0] bot;
      logic [FIELD_BITS-1:0] odd;
      int unsigned           twos;
      logic                  negative;
      bit                    finished;
      res.symbol      = SYM_ZERO;
      res.bad_modulus = 1'b0;
      if (n_in == '0) begin
         res.bad_modulus = 1'b1;
         return res;
      end
      top      = a_in;
      bot      = n_in;
      negative = 1'b0;
      finished = 1'b0;
      while (!finished) begin
         top = top % bot;
         if (top == '0) begin
            // A common factor leaves a modulus above one, and the symbol is then zero.
            if (bot == 1)
               res.symbol = negative ? SYM_MINUS : SYM_PLUS;
            finished = 1'b1;
         end else begin
            odd  = top;
            twos = 0;
            while (odd[0] == 1'b0) begin
               odd  = odd >> 1;
               twos = twos + 1;
            end
            // On the first round an even modulus also lands here, and it flips too.
            if (twos[0] && bot[2:0] != MOD8_ONE && bot[2:0] != MOD8_SEVEN)
               negative = !negative;
            if (odd[1:0] != MOD4_ONE && bot[1:0] != MOD4_ONE)
               negative = !negative;
            top = bot;
            bot = odd;
         end
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic jacobi_query_type make_query(logic [FIELD_BITS-1:0] a_in,
                                                   logic [FIELD_BITS-1:0] n_in,
                                                   bit hold);
      jacobi_query_type q;
      q.value_a       = a_in;
      q.modulus_n     = n_in;
      q.hold_for_idle = hold;
      return q;
   endfunction

   // Random pairs. Most have a full-width top argument and an odd modulus. The
   // rest are small operands, even or zero moduli, a modulus of one, pairs
   // that share a factor, and consecutive Fibonacci numbers, which give the
   // longest chains of rounds.
   function automatic jacobi_query_type random_query();
      logic [FIELD_BITS-1:0] a_val;
      logic [FIELD_BITS-1:0] n_val;
      logic [FIELD_BITS-1:0] fib_lo;
      logic [FIELD_BITS-1:0] fib_hi;
      logic [FIELD_BITS-1:0] fib_next;
      logic [FIELD_BITS-1:0] factor;
      int unsigned           pick;
      pick  = $urandom_range(0, 99);
      a_val = $urandom;
      n_val = $urandom;
      if (pick < 55) begin
         n_val[0] = 1'b1;
      end else if (pick < 70) begin
         a_val = $urandom_range(0, 300);
         n_val = $urandom_range(0, 150) * 2 + 1;
      end else if (pick < 80) begin
         n_val[0] = 1'b0;
         if (n_val == '0)
            n_val = 2;
      end else if (pick < 85) begin
         n_val = '0;
      end else if (pick < 90) begin
         n_val = 1;
      end else if (pick < 95) begin
         factor = $urandom_range(1, 1000) * 2 + 1;
         a_val  = factor * $urandom_range(0, 50000);
         n_val  = factor * ($urandom_range(0, 50000) * 2 + 1);
      end else begin
         fib_lo = 0;
         fib_hi = 1;
         repeat ($urandom_range(20, 46)) begin
            fib_next = fib_lo + fib_hi;
            fib_lo   = fib_hi;
            fib_hi   = fib_next;
         end
         a_val = fib_hi;
         n_val = fib_lo;
      end
      return make_query(a_val, n_val, 1'b0);
   endfunction

   // The stall pattern follows the progress of the run: first the sender idles
   // seldom and the receiver often, then the reverse, then neither idles.
   function automatic int unsigned sender_idle_pct(int done_items, int total_items);
      if (done_items < total_items / 3)
         return 19;
      else if (done_items < (2 * total_items) / 3)
         return 75;
      else
         return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct(int done_items, int total_items);
      if (done_items < total_items / 3)
         return 75;
      else if (done_items < (2 * total_items) / 3)
         return 19;
      else
         return 0;
   endfunction

   initial begin
      // The directed set: zero and unit moduli, zero and full-scale operands,
      // each symbol value, even moduli and a long Fibonacci chain.
      query_queue.push_back(make_query(32'h0000_0000, 32'h0000_0000, 1'b0));
      query_queue.push_back(make_query(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
      query_queue.push_back(make_query(32'h0000_0000, 32'h0000_0001, 1'b0));
      query_queue.push_back(make_query(32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
      query_queue.push_back(make_query(32'h0000_0000, 32'h0000_0003, 1'b0));
      query_queue.push_back(make_query(32'h0000_0000, 32'h0000_0002, 1'b0));
      query_queue.push_back(make_query(32'h0000_0002, 32'h0000_0003, 1'b0));
      query_queue.push_back(make_query(32'h0000_0002, 32'h0000_0007, 1'b0));
      query_queue.push_back(make_query(32'h0000_0003, 32'h0000_0005, 1'b1));
      query_queue.push_back(make_query(32'h0000_0005, 32'h0000_0003, 1'b0));
      query_queue.push_back(make_query(32'h0000_0003, 32'h0000_0009, 1'b0));
      query_queue.push_back(make_query(32'h0000_0009, 32'h0000_0009, 1'b0));
      query_queue.push_back(make_query(32'h0000_0005, 32'h0000_0008, 1'b0));
      query_queue.push_back(make_query(32'h0000_0007, 32'h8000_0000, 1'b0));
      query_queue.push_back(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0));
      query_queue.push_back(make_query(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0));
      query_queue.push_back(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      query_queue.push_back(make_query(32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
      query_queue.push_back(make_query(32'h0000_0001, 32'hFFFF_FFFF, 1'b0));
      query_queue.push_back(make_query(32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
      query_queue.push_back(make_query(32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
      query_queue.push_back(make_query(32'd2971215073, 32'd1836311903, 1'b0));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         query_queue.push_back(random_query());
         // Midway through the random part the sender waits for a quiet unit.
         if (i == RANDOM_ITEMS / 2)
            query_queue[query_queue.size() - 1].hold_for_idle = 1'b1;
      end
      item_total = query_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request has been taken and every response checked.
      // Then leave time for a stray response to show up.
      while (query_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (symbol_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   // The prediction is made when a request transaction is accepted. A new
   // request is offered only once the previous one has gone; until then tvalid
   // and tdata hold their values.
   always @(posedge clock) begin : request_driver
      jacobi_query_type next_query;
      bit               offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            symbol_queue.push_back(predict_jacobi(req_tdata[FIELD_BITS-1:0],
                                                  req_tdata[2*FIELD_BITS-1:FIELD_BITS]));
            accepted_items <= accepted_items + 1;
         end
         if (!req_tvalid || req_tready) begin
            offer = query_queue.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(accepted_items, item_total);
            if (offer && query_queue[0].hold_for_idle && symbol_queue.size() != 0)
               offer = 1'b0;
            if (offer) begin
               next_query = query_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {next_query.modulus_n, next_query.value_a};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------------

   // Each accepted response is compared with the oldest prediction: the symbol,
   // the error flag and the padding bits, which must stay zero.
   always @(posedge clock) begin : response_monitor
      jsu_result_type expected;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (symbol_queue.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response with nothing expected, tdata %h", $realtime, rsp_tdata);
            end else begin
               expected = symbol_queue.pop_front();
               if (rsp_tdata[SYMBOL_BITS-1:0] != expected.symbol ||
                   rsp_tdata[SYMBOL_BITS] != expected.bad_modulus ||
                   rsp_tdata[RSP_DATA_BITS-1:SYMBOL_BITS+1] != '0) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: symbol exp %b got %b, bad_modulus exp %b got %b, pad %b",
                              $realtime, expected.symbol, rsp_tdata[SYMBOL_BITS-1:0],
                              expected.bad_modulus, rsp_tdata[SYMBOL_BITS],
                              rsp_tdata[RSP_DATA_BITS-1:SYMBOL_BITS+1]);
               end
            end
         end
         rsp_tready <= $urandom_range(0, 99) >= receiver_idle_pct(accepted_items, item_total);
      end
   end

   // Guard against a hung unit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
